FILE: rtl/csa_pkg.sv
// Shared types and constants for the coordinated stepper axis core.
// Used by csa_muldiv and coordinated_stepper_axis_core; depends on nothing.
package csa_pkg;

  // Fixed geometry of the steering system and of the item fields.
  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = 2;
  localparam int ANGLE_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int SPT_W      = 16;

  // Angles are in 1/64 degree, so one output turn is 360 * 64 units.
  localparam int ANGLE_PER_TURN = 360 * 64;
  // Step period numerator scale.
  localparam int PERIOD_SCALE   = 1500;
  // Bits needed for the largest step target magnitude.
  localparam int TARGET_Q_W =
      $clog2(((2 ** (ANGLE_W - 1)) * (2 ** SPT_W - 1)) / ANGLE_PER_TURN + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_TURN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_WHEEL      = 1'd1;

  // Input item kinds.
  localparam logic ACT_TARGET = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Step sign codes, two's complement of -1, 0 and +1.
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_UP   = 2'b01;
  localparam logic [1:0] SIGN_DOWN = 2'b11;

  // Reset values and limits.
  localparam logic [SPT_W-1:0]    SPT_RESET    = 16'd3200;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd150;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hffff;

  typedef logic [ANGLE_W-1:0] csa_angle_t;

  // Status of the shared multiply-divide unit.
  typedef struct packed {
    logic done;
    logic sat;
  } csa_md_status_t;

endpackage

FILE: rtl/csa_muldiv.sv
// Bit-serial multiply-then-divide unit: q = floor(x * y / z), one bit per cycle.
// Depends on csa_pkg for the status struct.
module csa_muldiv import csa_pkg::*; #(
  parameter int XW = 18,
  parameter int QN = 18
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           md_start,
  input  logic [XW-1:0]  md_x,
  input  logic [XW-1:0]  md_y,
  input  logic [XW-1:0]  md_z,
  output logic [QN-1:0]  md_q,
  output csa_md_status_t md_stat
);

  localparam int CW = $clog2(QN + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_CHK  = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]      phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic            sat_r, sat_nxt;
  logic [2*XW-1:0] prod_r, prod_nxt;
  logic [XW-1:0]   mcand_r, mcand_nxt;
  logic [XW-1:0]   dvs_r, dvs_nxt;
  logic [XW-1:0]   rem_r, rem_nxt;
  logic [QN-1:0]   qsh_r, qsh_nxt;

  // Sequencer: shift-add multiply, overflow check, then restoring division.
  always_comb begin
    logic [XW:0]   sum;
    logic [XW-1:0] hi;
    logic [XW:0]   trial;
    logic          qbit;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    sat_nxt   = sat_r;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    qsh_nxt   = qsh_r;

    // One partial product per cycle, added into the high half.
    sum   = {1'b0, prod_r[2*XW-1:XW]} + {1'b0, (prod_r[0] ? mcand_r : {XW{1'b0}})};
    // Dividend bits above the quotient field; must stay below the divisor.
    hi    = XW'(prod_r >> QN);
    // One restoring division step.
    trial = {rem_r, qsh_r[QN-1]};
    qbit  = (trial >= {1'b0, dvs_r});

    unique case (phase_r)
      PH_IDLE: begin
        if (md_start) begin
          mcand_nxt = md_x;
          dvs_nxt   = md_z;
          prod_nxt  = {{XW{1'b0}}, md_y};
          cnt_nxt   = CW'(XW);
          sat_nxt   = 1'b0;
          phase_nxt = PH_MUL;
        end
      end
      PH_MUL: begin
        prod_nxt = {sum, prod_r[XW-1:1]};
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        if (hi >= dvs_r) begin
          // The quotient does not fit in QN bits.
          sat_nxt   = 1'b1;
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          rem_nxt   = hi;
          qsh_nxt   = prod_r[QN-1:0];
          cnt_nxt   = CW'(QN);
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        rem_nxt = qbit ? XW'(trial - {1'b0, dvs_r}) : trial[XW-1:0];
        qsh_nxt = {qsh_r[QN-2:0], qbit};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      sat_r   <= sat_nxt;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    qsh_r   <= qsh_nxt;
  end

  assign md_q         = qsh_r;
  assign md_stat.done = done_r;
  assign md_stat.sat  = sat_r;

endmodule

FILE: rtl/coordinated_stepper_axis_core.sv
// Top level of one axis of a four-wheel steering stepper controller.
// Depends on csa_pkg and instantiates csa_muldiv.
//
// Each accepted transaction yields exactly one result transaction. A target
// transaction runs up to nine multiply-divide operations on one shared
// bit-serial unit: four interpolations when the axis has not yet reached its
// target, four step targets and one period. The unit is sized with
// XW = max(POSITION_BITS, 16) and QN = max(POSITION_BITS, 17). A zero own
// distance skips the period division, and a period that saturates in the
// unit's overflow check skips its division steps. The result is held in an
// output register, so the next transaction is accepted while it waits; only a
// result that is still waiting when the next one is ready holds the sequencer
// in its last state.
module coordinated_stepper_axis_core import csa_pkg::*; #(
  parameter int POSITION_BITS = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [ANGLE_W-1:0]       in_angle_front_left,
  input  logic [ANGLE_W-1:0]       in_angle_front_right,
  input  logic [ANGLE_W-1:0]       in_angle_rear_left,
  input  logic [ANGLE_W-1:0]       in_angle_rear_right,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PERIOD_W-1:0]      out_step_period,
  output logic                     out_direction,
  output logic                     out_running,
  output logic [POSITION_BITS-1:0] out_position,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wr_data
);

  localparam int PB = POSITION_BITS;
  localparam int XW = (PB > ANGLE_W) ? PB : ANGLE_W;
  localparam int QN = (PB > TARGET_Q_W) ? PB : TARGET_Q_W;
  localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(NUM_WHEELS - 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_TICK   = 5'd1;
  localparam logic [4:0] ST_T_CHK  = 5'd2;
  localparam logic [4:0] ST_T_N    = 5'd3;
  localparam logic [4:0] ST_I_DIFF = 5'd4;
  localparam logic [4:0] ST_I_LOAD = 5'd5;
  localparam logic [4:0] ST_I_WAIT = 5'd6;
  localparam logic [4:0] ST_I_WB   = 5'd7;
  localparam logic [4:0] ST_G_LOAD = 5'd8;
  localparam logic [4:0] ST_G_WAIT = 5'd9;
  localparam logic [4:0] ST_G_NEG  = 5'd10;
  localparam logic [4:0] ST_G_DIFF = 5'd11;
  localparam logic [4:0] ST_G_DIST = 5'd12;
  localparam logic [4:0] ST_P_LOAD = 5'd13;
  localparam logic [4:0] ST_P_WAIT = 5'd14;
  localparam logic [4:0] ST_DIR    = 5'd15;
  localparam logic [4:0] ST_OUT    = 5'd16;

  logic [4:0]          state_r, state_nxt;
  logic [SPT_W-1:0]    spt_r, spt_nxt;
  logic [WHEEL_W-1:0]  wheel_r, wheel_nxt;

  logic [PB-1:0]       pos_r   [NUM_WHEELS];
  logic [PB-1:0]       pos_nxt [NUM_WHEELS];
  logic [PB-1:0]       tgt_r   [NUM_WHEELS];
  logic [PB-1:0]       tgt_nxt [NUM_WHEELS];
  logic [PB-1:0]       start_r [NUM_WHEELS];
  logic [PB-1:0]       start_nxt [NUM_WHEELS];
  logic [PB-1:0]       dist_r  [NUM_WHEELS];
  logic [PB-1:0]       dist_nxt [NUM_WHEELS];
  csa_angle_t          ang_r   [NUM_WHEELS];
  csa_angle_t          ang_nxt [NUM_WHEELS];

  logic [1:0]          sign_r, sign_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                run_r, run_nxt;

  logic [WHEEL_W-1:0]  idx_r, idx_nxt;
  logic [PB-1:0]       d_r, d_nxt;
  logic [PB-1:0]       n_r, n_nxt;
  logic [PB-1:0]       tnew_r, tnew_nxt;
  logic [PB-1:0]       gm_r, gm_nxt;
  logic [PB:0]         diff_r, diff_nxt;
  logic                neg_r, neg_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [PERIOD_W-1:0] out_period_r, out_period_nxt;
  logic                out_dir_r, out_dir_nxt;
  logic                out_run_r, out_run_nxt;
  logic [PB-1:0]       out_pos_r, out_pos_nxt;

  logic                loop_state;
  logic [WHEEL_W-1:0]  rd_idx;
  logic [PB-1:0]       pos_rd, tgt_rd, start_rd, dist_rd;
  csa_angle_t          ang_rd, ang_neg, ang_abs;
  logic [PB:0]         diff_neg;
  logic [PB-1:0]       diff_abs;
  logic [PB-1:0]       q_pos;

  logic                md_start;
  logic [XW-1:0]       md_x, md_y, md_z;
  logic [QN-1:0]       md_q;
  csa_md_status_t      md_stat;

  // Per-wheel loops use the loop index; everything else looks at the own wheel.
  assign loop_state = (state_r == ST_I_DIFF) || (state_r == ST_I_LOAD) ||
                      (state_r == ST_I_WAIT) || (state_r == ST_I_WB) ||
                      (state_r == ST_G_LOAD) || (state_r == ST_G_WAIT) ||
                      (state_r == ST_G_NEG) || (state_r == ST_G_DIFF) ||
                      (state_r == ST_G_DIST);
  assign rd_idx   = loop_state ? idx_r : wheel_r;
  assign pos_rd   = pos_r[rd_idx];
  assign tgt_rd   = tgt_r[rd_idx];
  assign start_rd = start_r[rd_idx];
  assign dist_rd  = dist_r[rd_idx];
  assign ang_rd   = ang_r[idx_r];

  // Magnitudes of the registered difference and of the current angle.
  assign diff_neg = ~diff_r + {{PB{1'b0}}, 1'b1};
  assign diff_abs = diff_r[PB] ? diff_neg[PB-1:0] : diff_r[PB-1:0];
  assign ang_neg  = ~ang_rd + ANGLE_W'(1);
  assign ang_abs  = ang_rd[ANGLE_W-1] ? ang_neg : ang_rd;
  assign q_pos    = md_q[PB-1:0];

  // Operand selection for the shared multiply-divide unit.
  always_comb begin
    unique case (state_r)
      ST_I_LOAD: begin
        md_x = XW'(diff_abs);
        md_y = XW'(n_r);
        md_z = XW'(d_r);
      end
      ST_G_LOAD: begin
        md_x = XW'(ang_abs);
        md_y = XW'(spt_r);
        md_z = XW'(ANGLE_PER_TURN);
      end
      default: begin
        md_x = XW'(gm_r);
        md_y = XW'(PERIOD_SCALE);
        md_z = XW'(dist_rd);
      end
    endcase
  end

  assign md_start = (state_r == ST_I_LOAD) || (state_r == ST_G_LOAD) ||
                    ((state_r == ST_P_LOAD) && (dist_rd != '0));

  csa_muldiv #(
    .XW (XW),
    .QN (QN)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .md_start (md_start),
    .md_x     (md_x),
    .md_y     (md_y),
    .md_z     (md_z),
    .md_q     (md_q),
    .md_stat  (md_stat)
  );

  // Main sequencer.
  always_comb begin
    state_nxt  = state_r;
    spt_nxt    = spt_r;
    wheel_nxt  = wheel_r;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      pos_nxt[i]   = pos_r[i];
      tgt_nxt[i]   = tgt_r[i];
      start_nxt[i] = start_r[i];
      dist_nxt[i]  = dist_r[i];
      ang_nxt[i]   = ang_r[i];
    end
    sign_nxt       = sign_r;
    period_nxt     = period_r;
    run_nxt        = run_r;
    idx_nxt        = idx_r;
    d_nxt          = d_r;
    n_nxt          = n_r;
    tnew_nxt       = tnew_r;
    gm_nxt         = gm_r;
    diff_nxt       = diff_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    out_period_nxt = out_period_r;
    out_dir_nxt    = out_dir_r;
    out_run_nxt    = out_run_r;
    out_pos_nxt    = out_pos_r;

    // The result register empties when its transaction completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STEPS_PER_TURN: spt_nxt   = cfg_wr_data[SPT_W-1:0];
        CFG_OWN_WHEEL:      wheel_nxt = cfg_wr_data[WHEEL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ang_nxt[0] = in_angle_front_left;
          ang_nxt[1] = in_angle_front_right;
          ang_nxt[2] = in_angle_rear_left;
          ang_nxt[3] = in_angle_rear_right;
          state_nxt  = (in_action == ACT_TICK) ? ST_TICK : ST_T_CHK;
        end
      end

      // One step toward the target, or stop there.
      ST_TICK: begin
        if (pos_rd == tgt_rd) begin
          run_nxt = 1'b0;
        end else begin
          pos_nxt[rd_idx] = pos_rd + {{(PB - 2){sign_r[1]}}, sign_r};
        end
        state_nxt = ST_OUT;
      end

      // Decide between interpolating along the old move and snapping to it.
      ST_T_CHK: begin
        idx_nxt = '0;
        gm_nxt  = '0;
        if (pos_rd != tgt_rd) begin
          d_nxt     = dist_rd;
          diff_nxt  = {pos_rd[PB-1], pos_rd} - {start_rd[PB-1], start_rd};
          state_nxt = ST_T_N;
        end else begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            pos_nxt[i] = tgt_r[i];
          end
          state_nxt = ST_G_LOAD;
        end
      end

      // Progress along the move, capped at the move length.
      ST_T_N: begin
        n_nxt     = (diff_abs > d_r) ? d_r : diff_abs;
        state_nxt = (d_r == '0) ? ST_G_LOAD : ST_I_DIFF;
      end

      // Interpolation: pos = start + trunc((target - start) * n / d).
      ST_I_DIFF: begin
        diff_nxt  = {tgt_rd[PB-1], tgt_rd} - {start_rd[PB-1], start_rd};
        state_nxt = ST_I_LOAD;
      end
      ST_I_LOAD: begin
        neg_nxt   = diff_r[PB];
        state_nxt = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        if (md_stat.done) begin
          state_nxt = ST_I_WB;
        end
      end
      ST_I_WB: begin
        pos_nxt[rd_idx] = neg_r ? (start_rd - q_pos) : (start_rd + q_pos);
        if (idx_r == LAST_WHEEL) begin
          idx_nxt   = '0;
          state_nxt = ST_G_LOAD;
        end else begin
          idx_nxt   = idx_r + WHEEL_W'(1);
          state_nxt = ST_I_DIFF;
        end
      end

      // New step targets: trunc(angle * steps_per_turn / one turn).
      ST_G_LOAD: begin
        neg_nxt   = ang_rd[ANGLE_W-1];
        state_nxt = ST_G_WAIT;
      end
      ST_G_WAIT: begin
        if (md_stat.done) begin
          state_nxt = ST_G_NEG;
        end
      end
      ST_G_NEG: begin
        tnew_nxt  = neg_r ? (~q_pos + PB'(1)) : q_pos;
        state_nxt = ST_G_DIFF;
      end
      ST_G_DIFF: begin
        tgt_nxt[rd_idx]   = tnew_r;
        start_nxt[rd_idx] = pos_rd;
        diff_nxt          = {tnew_r[PB-1], tnew_r} - {pos_rd[PB-1], pos_rd};
        state_nxt         = ST_G_DIST;
      end
      ST_G_DIST: begin
        dist_nxt[rd_idx] = diff_abs;
        if (diff_abs > gm_r) begin
          gm_nxt = diff_abs;
        end
        if (idx_r == LAST_WHEEL) begin
          state_nxt = ST_P_LOAD;
        end else begin
          idx_nxt   = idx_r + WHEEL_W'(1);
          state_nxt = ST_G_LOAD;
        end
      end

      // Period = 1500 * largest distance / own distance, saturated; kept when the own distance is zero.
      ST_P_LOAD: begin
        state_nxt = (dist_rd == '0) ? ST_DIR : ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (md_stat.done) begin
          if (md_stat.sat || (md_q[QN-1:PERIOD_W] != '0)) begin
            period_nxt = PERIOD_MAX;
          end else begin
            period_nxt = md_q[PERIOD_W-1:0];
          end
          state_nxt = ST_DIR;
        end
      end

      // Direction and run flag of the new move.
      ST_DIR: begin
        if ($signed(tgt_rd) > $signed(pos_rd)) begin
          sign_nxt = SIGN_UP;
          run_nxt  = 1'b1;
        end else if ($signed(tgt_rd) < $signed(pos_rd)) begin
          sign_nxt = SIGN_DOWN;
          run_nxt  = 1'b1;
        end else begin
          run_nxt  = 1'b0;
        end
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = period_r;
          out_dir_nxt    = (sign_r == SIGN_UP);
          out_run_nxt    = run_r;
          out_pos_nxt    = pos_rd;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spt_r       <= SPT_RESET;
      wheel_r     <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pos_r[i]   <= '0;
        tgt_r[i]   <= '0;
        start_r[i] <= '0;
      end
      sign_r      <= SIGN_ZERO;
      period_r    <= PERIOD_RESET;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spt_r       <= spt_nxt;
      wheel_r     <= wheel_nxt;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pos_r[i]   <= pos_nxt[i];
        tgt_r[i]   <= tgt_nxt[i];
        start_r[i] <= start_nxt[i];
      end
      sign_r      <= sign_nxt;
      period_r    <= period_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers; move distances are undefined until written.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      dist_r[i] <= dist_nxt[i];
      ang_r[i]  <= ang_nxt[i];
    end
    idx_r        <= idx_nxt;
    d_r          <= d_nxt;
    n_r          <= n_nxt;
    tnew_r       <= tnew_nxt;
    gm_r         <= gm_nxt;
    diff_r       <= diff_nxt;
    neg_r        <= neg_nxt;
    out_period_r <= out_period_nxt;
    out_dir_r    <= out_dir_nxt;
    out_run_r    <= out_run_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_step_period = out_period_r;
  assign out_direction   = out_dir_r;
  assign out_running     = out_run_r;
  assign out_position    = out_pos_r;

endmodule
